### rtl/nearest_neighbor_image_scaler_defines.svh
// assertion macros for the image scaler
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH

`ifndef ASSERT_OFF

// cons must hold in the same cycle as ante
`define NNS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define NNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define NNS_ASSERT_IMPLY(label, ante, cons)
`define NNS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/nns_pkg.sv
package nns_pkg;

  localparam int MAX_SRC_DIM = 64;
  localparam int MAX_DST_DIM = 1024;

  localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // fixed field widths
  localparam int COORD_W = 10;
  localparam int PIX_W   = 8;

  localparam int SRC_DIM_W  = $clog2(MAX_SRC_DIM + 1);
  localparam int DST_DIM_W  = $clog2(MAX_DST_DIM + 1);
  localparam int SRC_IDX_W  = $clog2(MAX_SRC_DIM);
  localparam int CFG_DATA_W = (SRC_DIM_W > DST_DIM_W) ? SRC_DIM_W : DST_DIM_W;
  localparam int CFG_IDX_W  = 2;

  // x * src_width stays below 2**PROD_W
  localparam int PROD_W = COORD_W + SRC_IDX_W;
  localparam int CNT_W  = $clog2(PROD_W);

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam int DIM_RESET = 64;

endpackage

### rtl/nearest_neighbor_image_scaler.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   command, coordinates, bgra pixel
// out      output     out_valid / out_stall bgra pixel, out_of_range flag
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// a write word leaves the block idle and gives no result
// a read inside the destination runs two 16-step restoring divisions on one shared
// divider, a multiply state before each, one store read and one output load; a read
// outside the destination goes straight to the output load; in_stall is high until it is emitted
// reset is synchronous, active low; the source store is not cleared
// a result waits in the output register while out_stall is high; a further read then waits in S_EMIT
`include "nearest_neighbor_image_scaler_defines.svh"

module nearest_neighbor_image_scaler
  import nns_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [COORD_W-1:0]    in_coord_x,
  input  logic [COORD_W-1:0]    in_coord_y,
  input  logic [PIX_W-1:0]      in_blue_in,
  input  logic [PIX_W-1:0]      in_green_in,
  input  logic [PIX_W-1:0]      in_red_in,
  input  logic [PIX_W-1:0]      in_alpha_in,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_blue_out,
  output logic [PIX_W-1:0]      out_green_out,
  output logic [PIX_W-1:0]      out_red_out,
  output logic [PIX_W-1:0]      out_alpha_out,
  output logic                  out_out_of_range
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_RD,
    S_EMIT
  } state_t;

  function automatic logic [SRC_DIM_W-1:0] eff_src(input logic [SRC_DIM_W-1:0] v);
    logic [SRC_DIM_W-1:0] r;
    if (v == '0) begin
      r = SRC_DIM_W'(1);
    end else if (v > SRC_DIM_W'(MAX_SRC_DIM)) begin
      r = SRC_DIM_W'(MAX_SRC_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DST_DIM_W-1:0] eff_dst(input logic [DST_DIM_W-1:0] v);
    logic [DST_DIM_W-1:0] r;
    if (v == '0) begin
      r = DST_DIM_W'(1);
    end else if (v > DST_DIM_W'(MAX_DST_DIM)) begin
      r = DST_DIM_W'(MAX_DST_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration registers
  logic [SRC_DIM_W-1:0] src_width_r, src_height_r;
  logic [DST_DIM_W-1:0] dst_width_r, dst_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_DIM_W'(DIM_RESET);
      src_height_r <= SRC_DIM_W'(DIM_RESET);
      dst_width_r  <= DST_DIM_W'(DIM_RESET);
      dst_height_r <= DST_DIM_W'(DIM_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SRC_DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[SRC_DIM_W-1:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata[DST_DIM_W-1:0];
        CFG_DST_HEIGHT: dst_height_r <= cfg_wdata[DST_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SRC_DIM_W-1:0] sw, sh;
  logic [DST_DIM_W-1:0] dw, dh;

  assign sw = eff_src(src_width_r);
  assign sh = eff_src(src_height_r);
  assign dw = eff_dst(dst_width_r);
  assign dh = eff_dst(dst_height_r);

  // sequencer state
  state_t               state_r, state_nxt;
  logic                 phase_r, phase_nxt;     // 0 column, 1 row
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PROD_W-1:0]    dq_r, dq_nxt;           // dividend out, quotient in
  logic [DST_DIM_W-1:0] rem_r, rem_nxt;
  logic [COORD_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic [SRC_IDX_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic                 oor_r, oor_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]     blue_r, blue_nxt, green_r, green_nxt;
  logic [PIX_W-1:0]     red_r, red_nxt, alpha_r, alpha_nxt;
  logic                 flag_r, flag_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic                 wr_inside, rd_outside;

  // shared multiplier and divider operands
  logic [COORD_W-1:0]   mul_a;
  logic [SRC_DIM_W-1:0] src_dim;
  logic [DST_DIM_W-1:0] div_d;
  logic [PROD_W-1:0]    product;
  logic [DST_DIM_W:0]   trial;
  logic                 ge;
  logic [DST_DIM_W:0]   diff;
  logic [PROD_W-1:0]    quot;
  logic [SRC_IDX_W-1:0] quot_clamped;

  // source store
  logic [4*PIX_W-1:0]   store [STORE_DEPTH];
  logic [4*PIX_W-1:0]   rd_data_r;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign wr_inside  = (in_coord_x < COORD_W'(sw)) && (in_coord_y < COORD_W'(sh));
  assign rd_outside = (DST_DIM_W'(in_coord_x) >= dw) || (DST_DIM_W'(in_coord_y) >= dh);

  assign mul_a   = phase_r ? y_r : x_r;
  assign src_dim = phase_r ? sh : sw;
  assign div_d   = phase_r ? dh : dw;
  assign product = PROD_W'(mul_a) * PROD_W'(src_dim);

  // one restoring division step
  assign trial = {rem_r, dq_r[PROD_W-1]};
  assign ge    = trial >= {1'b0, div_d};
  assign diff  = trial - {1'b0, div_d};
  assign quot  = {dq_r[PROD_W-2:0], ge};

  always_comb begin
    if (quot >= PROD_W'(src_dim)) begin
      quot_clamped = SRC_IDX_W'(src_dim - SRC_DIM_W'(1));
    end else begin
      quot_clamped = quot[SRC_IDX_W-1:0];
    end
  end

  assign wr_addr = ADDR_W'(in_coord_y[SRC_IDX_W-1:0] * MAX_SRC_DIM)
                 + ADDR_W'(in_coord_x[SRC_IDX_W-1:0]);
  assign rd_addr = ADDR_W'(sy_r * MAX_SRC_DIM) + ADDR_W'(sx_r);

  always_ff @(posedge clk) begin
    if (in_accept && (in_command == CMD_WRITE) && wr_inside) begin
      store[wr_addr] <= {in_alpha_in, in_red_in, in_green_in, in_blue_in};
    end
    rd_data_r <= store[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && out_stall;
    blue_nxt      = blue_r;
    green_nxt     = green_r;
    red_nxt       = red_r;
    alpha_nxt     = alpha_r;
    flag_nxt      = flag_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_command == CMD_READ)) begin
          x_nxt     = in_coord_x;
          y_nxt     = in_coord_y;
          phase_nxt = 1'b0;
          oor_nxt   = rd_outside;
          state_nxt = rd_outside ? S_EMIT : S_MUL;
        end
      end
      S_MUL: begin
        dq_nxt    = product;
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(PROD_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        dq_nxt  = quot;
        rem_nxt = ge ? diff[DST_DIM_W-1:0] : trial[DST_DIM_W-1:0];
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          if (!phase_r) begin
            sx_nxt    = quot_clamped;
            phase_nxt = 1'b1;
            state_nxt = S_MUL;
          end else begin
            sy_nxt    = quot_clamped;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          flag_nxt      = oor_r;
          if (oor_r) begin
            blue_nxt  = '0;
            green_nxt = '0;
            red_nxt   = '0;
            alpha_nxt = '0;
          end else begin
            alpha_nxt = rd_data_r[4*PIX_W-1:3*PIX_W];
            // colour is dropped under full transparency
            if (rd_data_r[4*PIX_W-1:3*PIX_W] == '0) begin
              blue_nxt  = '0;
              green_nxt = '0;
              red_nxt   = '0;
            end else begin
              blue_nxt  = rd_data_r[PIX_W-1:0];
              green_nxt = rd_data_r[2*PIX_W-1:PIX_W];
              red_nxt   = rd_data_r[3*PIX_W-1:2*PIX_W];
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    oor_r   <= oor_nxt;
    blue_r  <= blue_nxt;
    green_r <= green_nxt;
    red_r   <= red_nxt;
    alpha_r <= alpha_nxt;
    flag_r  <= flag_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_blue_out     = blue_r;
  assign out_green_out    = green_r;
  assign out_red_out      = red_r;
  assign out_alpha_out    = alpha_r;
  assign out_out_of_range = flag_r;

  `NNS_ASSERT_IMPLY(a_transparent_black, out_valid_r && (alpha_r == '0),
                    (blue_r == '0) && (green_r == '0) && (red_r == '0))
  `NNS_ASSERT_IMPLY(a_oor_zero_alpha, out_valid_r && flag_r, alpha_r == '0)
  `NNS_ASSERT_NEXT(a_row_div_done, (state_r == S_DIV) && phase_r && (cnt_r == '0),
                   state_r == S_RD)
  `NNS_ASSERT_IMPLY(a_src_col_inside, state_r == S_RD,
                    (SRC_DIM_W'(sx_r) < sw) && (SRC_DIM_W'(sy_r) < sh))

endmodule

### bench/nearest_neighbor_image_scaler_tb.sv
module nearest_neighbor_image_scaler_tb;
  import nns_pkg::*;

  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 300;
  localparam int PRINT_CAP     = 60;
  localparam int COORD_MAX     = (1 << COORD_W) - 1;

  typedef struct {
    logic               command;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   alpha;
  } scaler_word_t;

  typedef struct {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] alpha;
    logic             out_of_range;
  } pixel_result_t;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_index;
    int unsigned           reg_value;
    scaler_word_t          word;
    bit                    typed;
    pixel_result_t         known;
  } stimulus_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_command;
  logic [COORD_W-1:0]    in_coord_x;
  logic [COORD_W-1:0]    in_coord_y;
  logic [PIX_W-1:0]      in_blue_in;
  logic [PIX_W-1:0]      in_green_in;
  logic [PIX_W-1:0]      in_red_in;
  logic [PIX_W-1:0]      in_alpha_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      out_blue_out;
  logic [PIX_W-1:0]      out_green_out;
  logic [PIX_W-1:0]      out_red_out;
  logic [PIX_W-1:0]      out_alpha_out;
  logic                  out_out_of_range;

  nearest_neighbor_image_scaler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_blue_in       (in_blue_in),
    .in_green_in      (in_green_in),
    .in_red_in        (in_red_in),
    .in_alpha_in      (in_alpha_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_blue_out     (out_blue_out),
    .out_green_out    (out_green_out),
    .out_red_out      (out_red_out),
    .out_alpha_out    (out_alpha_out),
    .out_out_of_range (out_out_of_range)
  );

  // scaler image of the block
  logic [4*PIX_W-1:0]    source_pixels [STORE_DEPTH];
  bit                    pixel_written [STORE_DEPTH];
  logic [SRC_DIM_W-1:0]  src_width_q;
  logic [SRC_DIM_W-1:0]  src_height_q;
  logic [DST_DIM_W-1:0]  dst_width_q;
  logic [DST_DIM_W-1:0]  dst_height_q;

  pixel_result_t pending_pixels [$];
  stimulus_row_t directed_rows [$];

  int unsigned failures;
  int unsigned reads_total;
  int unsigned oor_total;
  int unsigned stores_total;
  int unsigned dropped_total;
  int unsigned settings_total;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_pending;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned eff_size(input int unsigned v, input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic int unsigned src_cols();
    return eff_size(32'(src_width_q), MAX_SRC_DIM);
  endfunction

  function automatic int unsigned src_rows();
    return eff_size(32'(src_height_q), MAX_SRC_DIM);
  endfunction

  function automatic int unsigned dst_cols();
    return eff_size(32'(dst_width_q), MAX_DST_DIM);
  endfunction

  function automatic int unsigned dst_rows();
    return eff_size(32'(dst_height_q), MAX_DST_DIM);
  endfunction

  function automatic int unsigned scale_coord(input int unsigned pos, input int unsigned src,
                                              input int unsigned dst);
    int unsigned s;
    s = (pos * src) / dst;
    if (s >= src) s = src - 1;
    return s;
  endfunction

  // store address a read inside the destination picks, under the current sizes
  function automatic int unsigned source_addr(input int unsigned x, input int unsigned y);
    int unsigned sx;
    int unsigned sy;
    sx = scale_coord(x, src_cols(), dst_cols());
    sy = scale_coord(y, src_rows(), dst_rows());
    return sy * MAX_SRC_DIM + sx;
  endfunction

  function automatic bit in_destination(input int unsigned x, input int unsigned y);
    return x < dst_cols() && y < dst_rows();
  endfunction

  function automatic bit scale_word(input scaler_word_t w, output pixel_result_t r);
    logic [4*PIX_W-1:0] px;
    int unsigned        addr;
    int unsigned        x;
    int unsigned        y;
    r = '{default: '0};
    x = 32'(w.x);
    y = 32'(w.y);
    if (w.command == CMD_WRITE) begin
      if (x < src_cols() && y < src_rows()) begin
        addr = y * MAX_SRC_DIM + x;
        source_pixels[addr] = {w.alpha, w.red, w.green, w.blue};
        pixel_written[addr] = 1'b1;
        stores_total++;
      end else begin
        dropped_total++;
      end
      return 1'b0;
    end
    reads_total++;
    if (!in_destination(x, y)) begin
      r.out_of_range = 1'b1;
      oor_total++;
      return 1'b1;
    end
    px = source_pixels[source_addr(x, y)];
    r.alpha = px[31:24];
    // colour is blanked on fully transparent pixels
    if (r.alpha != '0) begin
      r.blue  = px[7:0];
      r.green = px[15:8];
      r.red   = px[23:16];
    end
    return 1'b1;
  endfunction

  function automatic scaler_word_t make_word(input logic cmd, input int unsigned x,
                                             input int unsigned y, input logic [31:0] argb);
    scaler_word_t w;
    w.command = cmd;
    w.x       = x[COORD_W-1:0];
    w.y       = y[COORD_W-1:0];
    w.blue    = argb[7:0];
    w.green   = argb[15:8];
    w.red     = argb[23:16];
    w.alpha   = argb[31:24];
    return w;
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    px = $urandom;
    if ($urandom_range(0, 5) == 0) px[31:24] = '0;
    return px;
  endfunction

  function automatic void add_word(input logic cmd, input int unsigned x, input int unsigned y,
                                   input logic [31:0] argb);
    stimulus_row_t row;
    row = '{default: '0};
    row.word = make_word(cmd, x, y, argb);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_read_known(input int unsigned x, input int unsigned y,
                                         input logic [31:0] argb, input logic oor);
    stimulus_row_t row;
    row = '{default: '0};
    row.word               = make_word(CMD_READ, x, y, '0);
    row.typed              = 1'b1;
    row.known.blue         = argb[7:0];
    row.known.green        = argb[15:8];
    row.known.red          = argb[23:16];
    row.known.alpha        = argb[31:24];
    row.known.out_of_range = oor;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    stimulus_row_t row;
    row = '{default: '0};
    row.is_reg    = 1'b1;
    row.reg_index = idx;
    row.reg_value = val;
    directed_rows.push_back(row);
  endfunction

  task automatic report_failure(input string msg);
    if (failures < PRINT_CAP) $display("%0t  error: %s", $time, msg);
    failures++;
  endtask

  task automatic check_lane(input string name, input logic [PIX_W-1:0] got,
                            input logic [PIX_W-1:0] want);
    if (got !== want) report_failure($sformatf("%s got %02h want %02h", name, got, want));
  endtask

  // all tasks below start and end just after a rising edge
  task automatic send_word(input scaler_word_t w, input bit typed, input pixel_result_t known);
    pixel_result_t r;
    int unsigned   gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= w.command;
    in_coord_x  <= w.x;
    in_coord_y  <= w.y;
    in_blue_in  <= w.blue;
    in_green_in <= w.green;
    in_red_in   <= w.red;
    in_alpha_in <= w.alpha;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (scale_word(w, r)) begin
      if (typed)
        pending_pixels.push_back(known);
      else
        pending_pixels.push_back(r);
    end
  endtask

  // a read may only land on a stored pixel, so fill the entry first when needed
  task automatic send_read(input int unsigned x, input int unsigned y);
    pixel_result_t none;
    int unsigned   addr;
    none = '{default: '0};
    if (in_destination(x, y)) begin
      addr = source_addr(x, y);
      if (!pixel_written[addr])
        send_word(make_word(CMD_WRITE, addr % MAX_SRC_DIM, addr / MAX_SRC_DIM, random_pixel()),
                  1'b0, none);
    end
    send_word(make_word(CMD_READ, x, y, '0), 1'b0, none);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // a trailing pixel store may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] data;
    data = val[CFG_DATA_W-1:0];
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH:  src_width_q  = data[SRC_DIM_W-1:0];
      CFG_SRC_HEIGHT: src_height_q = data[SRC_DIM_W-1:0];
      CFG_DST_WIDTH:  dst_width_q  = data[DST_DIM_W-1:0];
      CFG_DST_HEIGHT: dst_height_q = data[DST_DIM_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_sizes(input int unsigned sw, input int unsigned sh,
                               input int unsigned dw, input int unsigned dh);
    wait_idle();
    write_register(CFG_SRC_WIDTH, sw);
    write_register(CFG_SRC_HEIGHT, sh);
    write_register(CFG_DST_WIDTH, dw);
    write_register(CFG_DST_HEIGHT, dh);
    settings_total++;
  endtask

  // mostly legal sizes, now and then zero or above the limit
  function automatic int unsigned rand_size(input int unsigned limit, input int unsigned reg_max);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(limit + 1, reg_max);
      2:       return limit;
      3:       return 1;
      default: return $urandom_range(1, limit);
    endcase
  endfunction

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    int unsigned hold_count;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall <= 1'b1;
        for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_pixels.size() == 0) begin
        report_failure("result word with nothing pending");
      end else begin
        want = pending_pixels.pop_front();
        check_lane("blue", out_blue_out, want.blue);
        check_lane("green", out_green_out, want.green);
        check_lane("red", out_red_out, want.red);
        check_lane("alpha", out_alpha_out, want.alpha);
        check_lane("out_of_range", {7'd0, out_out_of_range}, {7'd0, want.out_of_range});
      end
    end
  end

  initial begin : stimulus
    stimulus_row_t row;
    pixel_result_t none;
    bit            prev_reg;
    int unsigned   phase;
    int unsigned   base;
    int unsigned   roll;
    int unsigned   sw;
    int unsigned   sh;
    int unsigned   dw;
    int unsigned   dh;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_SRC_WIDTH;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_command  = CMD_WRITE;
    in_coord_x  = '0;
    in_coord_y  = '0;
    in_blue_in  = '0;
    in_green_in = '0;
    in_red_in   = '0;
    in_alpha_in = '0;
    none        = '{default: '0};
    failures    = 0;
    reads_total = 0;
    oor_total   = 0;
    stores_total   = 0;
    dropped_total  = 0;
    settings_total = 0;
    hold_off_pending = 1'b0;
    send_idle_pct  = 30;
    recv_idle_pct  = 30;
    src_width_q  = SRC_DIM_W'(DIM_RESET);
    src_height_q = SRC_DIM_W'(DIM_RESET);
    dst_width_q  = DST_DIM_W'(DIM_RESET);
    dst_height_q = DST_DIM_W'(DIM_RESET);

    // reset sizes map the destination one to one onto the source
    add_word(CMD_WRITE, 0, 0, 32'hFF030201);
    add_read_known(0, 0, 32'hFF030201, 1'b0);
    add_word(CMD_WRITE, 63, 63, 32'hFFFFFFFF);
    add_read_known(63, 63, 32'hFFFFFFFF, 1'b0);
    add_word(CMD_WRITE, 5, 7, 32'h00AA55AA);
    add_read_known(5, 7, 32'h00000000, 1'b0);
    add_word(CMD_WRITE, 0, 1, 32'h40302010);
    // column 64 of row 0 would alias row 1 if not dropped
    add_word(CMD_WRITE, 64, 0, 32'hEEEEEEEE);
    add_read_known(0, 1, 32'h40302010, 1'b0);
    add_word(CMD_WRITE, COORD_MAX, COORD_MAX, 32'hFFFFFFFF);
    add_read_known(64, 0, 32'h0, 1'b1);
    add_read_known(0, 64, 32'h0, 1'b1);
    add_read_known(COORD_MAX, COORD_MAX, 32'h0, 1'b1);
    // zero and oversized registers
    add_reg(CFG_SRC_WIDTH, 0);
    add_reg(CFG_SRC_HEIGHT, 127);
    add_reg(CFG_DST_WIDTH, 2047);
    add_reg(CFG_DST_HEIGHT, 0);
    add_word(CMD_READ, COORD_MAX, 0, '0);
    add_read_known(0, 1, 32'h0, 1'b1);
    add_word(CMD_WRITE, 0, 63, 32'h01204080);
    add_word(CMD_WRITE, 1, 0, 32'h12345678);
    add_reg(CFG_SRC_WIDTH, MAX_SRC_DIM);
    add_reg(CFG_DST_HEIGHT, MAX_DST_DIM);
    add_word(CMD_READ, COORD_MAX, COORD_MAX, '0);
    add_word(CMD_READ, 0, COORD_MAX, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_reg = 1'b1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) begin
        if (!prev_reg) wait_idle();
        write_register(row.reg_index, row.reg_value);
      end else begin
        send_word(row.word, row.typed, row.known);
      end
      prev_reg = row.is_reg;
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_sizes(1, 1, 1, 1);
        1: program_sizes(MAX_SRC_DIM, MAX_SRC_DIM, MAX_DST_DIM, MAX_DST_DIM);
        2: program_sizes(MAX_SRC_DIM, MAX_SRC_DIM, 1, 1);
        3: program_sizes(1, MAX_SRC_DIM, MAX_DST_DIM, 3);
        4: program_sizes(0, 127, 0, 2047);
        default: program_sizes(rand_size(MAX_SRC_DIM, 127), rand_size(MAX_SRC_DIM, 127),
                               rand_size(MAX_DST_DIM, 2047), rand_size(MAX_DST_DIM, 2047));
      endcase
      if (phase == PHASES - 1 || phase % 3 == 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(10, 40);
        recv_idle_pct = $urandom_range(10, 50);
      end
      // output held off while reads keep coming in
      if (phase == 5) hold_off_pending = 1'b1;

      sw = src_cols();
      sh = src_rows();
      dw = dst_cols();
      dh = dst_rows();
      base = reads_total + stores_total;
      while (reads_total + stores_total - base < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 50)
          send_read($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
        else if (roll < 80)
          send_word(make_word(CMD_WRITE, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                              random_pixel()), 1'b0, none);
        else if (roll < 90)
          send_read($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        else
          send_word(make_word(CMD_WRITE, $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), random_pixel()), 1'b0, none);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d reads (%0d outside the destination), %0d pixel stores, %0d dropped",
             reads_total, oor_total, stores_total, dropped_total);
    $display("over %0d size settings incl. zero and oversized registers and a long output hold",
             settings_total);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #10000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
